// ===== hdl/two_row_text_console_buffer_core_macros.svh =====
// Assertion macros for the text console buffer.
// Included by the top level; depends on nothing else.
`ifndef TWO_ROW_TEXT_CONSOLE_BUFFER_CORE_MACROS_SVH
`define TWO_ROW_TEXT_CONSOLE_BUFFER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tbc_pkg.sv =====
// Package for the text console buffer: sizes, character codes, opcodes and
// the structs passed between the control logic and the top level.
`default_nettype none

package tbc_pkg;

    localparam int ROWS    = 2;
    localparam int COLUMNS = 21;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int IDX_W   = (CELLS > 1) ? $clog2(CELLS) : 1;

    // Field widths of the item and result.
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 1;
    localparam int COL_W  = 5;

    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_ACK   = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             pend;
        logic             dirty;
    } t_state;

    typedef struct packed {
        t_state            nxt;
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [CHAR_W-1:0] wdata;
        logic              clr;
        logic              re;
        logic [IDX_W-1:0]  raddr;
        logic [CHAR_W-1:0] res_char;
        logic              rd_sel;
        logic              written;
        logic [ROW_W-1:0]  wrow;
        logic [COL_W-1:0]  wcol;
        logic              cleared;
    } t_ctrl;

    function automatic logic [IDX_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_index = IDX_W'(int'(row) * COLUMNS + int'(col));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tbc_if.sv =====
// Valid/ready channel interfaces for the text console buffer.
// Depends on tbc_pkg for the field widths.
`default_nettype none

interface tbc_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [tbc_pkg::OP_W-1:0]     opcode;
    logic [tbc_pkg::CHAR_W-1:0]   data_byte;
    logic [tbc_pkg::ROW_W-1:0]    read_row;
    logic [tbc_pkg::COL_W-1:0]    read_column;

    modport source (output valid, opcode, data_byte, read_row, read_column, input ready);
    modport sink   (input valid, opcode, data_byte, read_row, read_column, output ready);
endinterface

interface tbc_res_if;
    logic                         valid;
    logic                         ready;
    logic [tbc_pkg::CHAR_W-1:0]   cell_char;
    logic                         char_written;
    logic [tbc_pkg::ROW_W-1:0]    written_row;
    logic [tbc_pkg::COL_W-1:0]    written_column;
    logic                         store_cleared;
    logic                         needs_redraw;

    modport source (output valid, cell_char, char_written, written_row, written_column,
                    store_cleared, needs_redraw, input ready);
    modport sink   (input valid, cell_char, char_written, written_row, written_column,
                    store_cleared, needs_redraw, output ready);
endinterface

`default_nettype wire

// ===== hdl/tbc_ctrl.sv =====
// Cursor and command decode for the text console buffer: computes the next
// cursor state, the store access and the result fields of one transaction.
// Depends on tbc_pkg.
`default_nettype none

module tbc_ctrl (
    input  wire logic [tbc_pkg::OP_W-1:0]   i_opcode,
    input  wire logic [tbc_pkg::CHAR_W-1:0] i_data_byte,
    input  wire logic [tbc_pkg::ROW_W-1:0]  i_read_row,
    input  wire logic [tbc_pkg::COL_W-1:0]  i_read_column,
    input  wire tbc_pkg::t_state            i_state,
    output tbc_pkg::t_ctrl                  o_ctrl
);

    typedef tbc_pkg::t_state t_state_work;

    logic [tbc_pkg::CHAR_W-1:0] char_val;
    t_state_work                w;

    always_comb begin
        if (i_data_byte inside {[tbc_pkg::CH_SPACE:tbc_pkg::CH_TILDE]}) begin
            char_val = i_data_byte;
        end else begin
            char_val = tbc_pkg::CH_DOT;
        end
    end

    always_comb begin
        w      = i_state;
        o_ctrl = '0;

        case (tbc_pkg::t_opcode'(i_opcode))
            tbc_pkg::OP_PUT: begin
                if (i_data_byte == tbc_pkg::CH_CR) begin
                    // Carriage return leaves everything alone.
                end else if (i_data_byte == tbc_pkg::CH_LF) begin
                    if (int'(w.row) + 1 < tbc_pkg::ROWS) begin
                        w.row = w.row + 1'b1;
                        w.col = '0;
                    end else begin
                        w.pend = 1'b1;
                    end
                end else begin
                    if (w.pend) begin
                        o_ctrl.clr = 1'b1;
                    end else if (int'(w.col) >= tbc_pkg::COLUMNS) begin
                        if (int'(w.row) + 1 < tbc_pkg::ROWS) begin
                            w.row = w.row + 1'b1;
                            w.col = '0;
                        end else begin
                            o_ctrl.clr = 1'b1;
                        end
                    end
                    if (o_ctrl.clr) begin
                        w.row   = '0;
                        w.col   = '0;
                        w.pend  = 1'b0;
                        w.dirty = 1'b1;
                    end
                    if (int'(w.row) < tbc_pkg::ROWS && int'(w.col) < tbc_pkg::COLUMNS) begin
                        o_ctrl.we       = 1'b1;
                        o_ctrl.waddr    = tbc_pkg::cell_index(w.row, w.col);
                        o_ctrl.wdata    = char_val;
                        o_ctrl.res_char = char_val;
                        o_ctrl.written  = 1'b1;
                        o_ctrl.wrow     = w.row;
                        o_ctrl.wcol     = w.col;
                        w.col           = w.col + 1'b1;
                        w.dirty         = 1'b1;
                    end
                    o_ctrl.cleared = o_ctrl.clr;
                end
            end
            tbc_pkg::OP_READ: begin
                if (int'(i_read_row) < tbc_pkg::ROWS &&
                    int'(i_read_column) < tbc_pkg::COLUMNS) begin
                    o_ctrl.re     = 1'b1;
                    o_ctrl.raddr  = tbc_pkg::cell_index(i_read_row, i_read_column);
                    o_ctrl.rd_sel = 1'b1;
                end
            end
            tbc_pkg::OP_ACK: begin
                w.dirty = 1'b0;
            end
            tbc_pkg::OP_CLEAR: begin
                o_ctrl.clr     = 1'b1;
                o_ctrl.cleared = 1'b1;
                w.row          = '0;
                w.col          = '0;
                w.pend         = 1'b0;
                w.dirty        = 1'b1;
            end
            default: begin
            end
        endcase

        o_ctrl.nxt = w;
    end

endmodule

`default_nettype wire

// ===== hdl/tbc_store.sv =====
// Character store of the text console buffer: a memory with one write and
// one registered read port, and a valid bit per cell that reads back a space
// for any cell not written since the last clear. Depends on tbc_pkg.
`default_nettype none

module tbc_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_we,
    input  wire logic [tbc_pkg::IDX_W-1:0]  i_waddr,
    input  wire logic [tbc_pkg::CHAR_W-1:0] i_wdata,
    input  wire logic                       i_clr,
    input  wire logic                       i_re,
    input  wire logic [tbc_pkg::IDX_W-1:0]  i_raddr,
    output logic      [tbc_pkg::CHAR_W-1:0] o_rdata
);

    logic [tbc_pkg::CHAR_W-1:0] mem [tbc_pkg::CELLS];
    logic [tbc_pkg::CELLS-1:0]  r_valid;
    logic [tbc_pkg::CELLS-1:0]  n_valid;
    logic [tbc_pkg::CHAR_W-1:0] r_q;
    logic                       r_q_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= mem[i_raddr];
        end
    end

    // A clear drops every valid bit; a write in the same transaction lands after it.
    always_comb begin
        n_valid = i_clr ? '0 : r_valid;
        if (i_we) begin
            n_valid[i_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_re) begin
                r_q_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_q_valid ? r_q : tbc_pkg::CH_SPACE;

endmodule

`default_nettype wire

// ===== hdl/two_row_text_console_buffer_core.sv =====
// Top level of the two-row text console buffer: cursor state registers,
// result register and the character store. Depends on tbc_pkg, tbc_if,
// tbc_ctrl, tbc_store and the assertion macro header.
`default_nettype none
`include "two_row_text_console_buffer_core_macros.svh"

// Each command transaction is decoded and applied in the cycle it is accepted:
// the cursor registers and the character store are updated at that clock edge
// and the result is loaded into the output register at the same edge. The block
// takes one transaction per cycle for as long as the result register is empty
// or its content is taken in the same cycle; the result register is the only
// stage. The store is a 42-entry memory with a registered read port and one
// valid bit per cell, so reset and the clear operations take effect at once,
// with no clearing pass. A cell not written since the last clear reads as a
// space.
module two_row_text_console_buffer_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tbc_cmd_if.sink    i_cmd,
    tbc_res_if.source  o_res
);

    tbc_pkg::t_state            r_state;
    tbc_pkg::t_ctrl             ctrl;
    logic                       accept;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic [tbc_pkg::CHAR_W-1:0] r_cell;
    logic                       r_rd_sel;
    logic                       r_written;
    logic [tbc_pkg::ROW_W-1:0]  r_wrow;
    logic [tbc_pkg::COL_W-1:0]  r_wcol;
    logic                       r_cleared;
    logic                       r_redraw;
    logic [tbc_pkg::CHAR_W-1:0] rd_char;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    tbc_ctrl u_ctrl (
        .i_opcode      (i_cmd.opcode),
        .i_data_byte   (i_cmd.data_byte),
        .i_read_row    (i_cmd.read_row),
        .i_read_column (i_cmd.read_column),
        .i_state       (r_state),
        .o_ctrl        (ctrl)
    );

    tbc_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (accept && ctrl.we),
        .i_waddr (ctrl.waddr),
        .i_wdata (ctrl.wdata),
        .i_clr   (accept && ctrl.clr),
        .i_re    (accept && ctrl.re),
        .i_raddr (ctrl.raddr),
        .o_rdata (rd_char)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.row   <= '0;
            r_state.col   <= '0;
            r_state.pend  <= 1'b0;
            r_state.dirty <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_state <= ctrl.nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cell    <= ctrl.res_char;
            r_rd_sel  <= ctrl.rd_sel;
            r_written <= ctrl.written;
            r_wrow    <= ctrl.wrow;
            r_wcol    <= ctrl.wcol;
            r_cleared <= ctrl.cleared;
            r_redraw  <= ctrl.nxt.dirty;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.cell_char      = r_rd_sel ? rd_char : r_cell;
    assign o_res.char_written   = r_written;
    assign o_res.written_row    = r_wrow;
    assign o_res.written_column = r_wcol;
    assign o_res.store_cleared  = r_cleared;
    assign o_res.needs_redraw   = r_redraw;

    `TBC_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, accept, r_out_valid, "accepted transaction produced no result")
    `TBC_ASSERT_NOW(a_cursor_in_range, i_clk, i_rst_n, 1'b1, int'(r_state.col) <= tbc_pkg::COLUMNS, "cursor column beyond row end")
    `TBC_ASSERT_NOW(a_clear_writes_home, i_clk, i_rst_n, r_out_valid && r_cleared && r_written, r_wrow == '0 && r_wcol == '0, "character after clear not at home position")
    `TBC_ASSERT_NOW(a_write_sets_dirty, i_clk, i_rst_n, r_out_valid && (r_written || r_cleared), r_redraw, "store changed without dirty flag")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the two-row text console buffer core.
// Drives commands, predicts each result from a shadow copy of the console state
// or uses a scripted one, and checks it field by field. Depends on tbc_pkg, tbc_if.

module tb_top;
    import tbc_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic              char_written;
        logic [ROW_W-1:0]  written_row;
        logic [COL_W-1:0]  written_column;
        logic              store_cleared;
        logic              needs_redraw;
    } console_result_t;

    typedef struct {
        t_opcode           op;
        logic [CHAR_W-1:0] data;
        logic [ROW_W-1:0]  rrow;
        logic [COL_W-1:0]  rcol;
        int                reps;
        bit                typed;
        console_result_t   res;
    } stim_row_t;

    localparam int RANDOM_ITEMS = 384;
    localparam int QUIET_ITEMS  = 60;

    logic clk;
    logic rst_n;

    tbc_cmd_if cmd_ch ();
    tbc_res_if res_ch ();

    two_row_text_console_buffer_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // Shadow copy of the console state.
    logic [CHAR_W-1:0] shadow_cells [CELLS];
    logic [ROW_W-1:0]  shadow_row;
    logic [COL_W-1:0]  shadow_col;
    logic              shadow_pend;
    logic              shadow_dirty;

    console_result_t expected_results [$];
    stim_row_t       script [$];
    int              fail_count = 0;
    bit              quiet_tail = 1'b0;

    // Travels with the command so the monitor can use a hand-written result.
    bit              drv_typed;
    console_result_t drv_typed_res;

    initial begin
        clk = 1'b0;
    end

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void console_wipe();
        foreach (shadow_cells[i]) shadow_cells[i] = CH_SPACE;
        shadow_row   = '0;
        shadow_col   = '0;
        shadow_pend  = 1'b0;
        shadow_dirty = 1'b1;
    endfunction

    function automatic console_result_t console_apply(input t_opcode op,
                                                      input logic [CHAR_W-1:0] data,
                                                      input logic [ROW_W-1:0] rrow,
                                                      input logic [COL_W-1:0] rcol);
        console_result_t r;
        logic [CHAR_W-1:0] ch;
        r  = '0;
        ch = data;
        case (op)
            OP_PUT: begin
                if (data == CH_LF) begin
                    if (int'(shadow_row) + 1 < ROWS) begin
                        shadow_row++;
                        shadow_col = '0;
                    end else begin
                        shadow_pend = 1'b1;
                    end
                end else if (data != CH_CR) begin
                    // A line feed on the last row, or a full last row, clears
                    // the screen before the next character lands.
                    if (shadow_pend) begin
                        console_wipe();
                        r.store_cleared = 1'b1;
                    end else if (int'(shadow_col) >= COLUMNS) begin
                        if (int'(shadow_row) + 1 < ROWS) begin
                            shadow_row++;
                            shadow_col = '0;
                        end else begin
                            console_wipe();
                            r.store_cleared = 1'b1;
                        end
                    end
                    if (ch < CH_SPACE || ch > CH_TILDE) ch = CH_DOT;
                    if (int'(shadow_row) < ROWS && int'(shadow_col) < COLUMNS) begin
                        shadow_cells[int'(shadow_row) * COLUMNS + int'(shadow_col)] = ch;
                        r.cell_char      = ch;
                        r.char_written   = 1'b1;
                        r.written_row    = shadow_row;
                        r.written_column = shadow_col;
                        shadow_col++;
                        shadow_dirty = 1'b1;
                    end
                end
            end
            OP_READ: begin
                if (int'(rrow) < ROWS && int'(rcol) < COLUMNS) begin
                    r.cell_char = shadow_cells[int'(rrow) * COLUMNS + int'(rcol)];
                end
            end
            OP_ACK: begin
                shadow_dirty = 1'b0;
            end
            default: begin
                console_wipe();
                r.store_cleared = 1'b1;
            end
        endcase
        r.needs_redraw = shadow_dirty;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Scoreboard: results are checked before the command of the same edge is
    // predicted, since a command's result is registered when it is accepted.
    always @(posedge clk) begin
        console_result_t seen;
        console_result_t want;
        if (!rst_n) begin
            console_wipe();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                seen = '{res_ch.cell_char, res_ch.char_written, res_ch.written_row,
                         res_ch.written_column, res_ch.store_cleared, res_ch.needs_redraw};
                if (expected_results.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("cell_char", want.cell_char, seen.cell_char);
                    check_field("char_written", want.char_written, seen.char_written);
                    check_field("written_row", want.written_row, seen.written_row);
                    check_field("written_column", want.written_column, seen.written_column);
                    check_field("store_cleared", want.store_cleared, seen.store_cleared);
                    check_field("needs_redraw", want.needs_redraw, seen.needs_redraw);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                want = console_apply(t_opcode'(cmd_ch.opcode), cmd_ch.data_byte,
                                     cmd_ch.read_row, cmd_ch.read_column);
                if (drv_typed) want = drv_typed_res;
                expected_results.push_back(want);
            end
        end
    end

    function automatic void add_row(input t_opcode op, input logic [CHAR_W-1:0] data,
                                    input logic [ROW_W-1:0] rrow,
                                    input logic [COL_W-1:0] rcol, input int reps,
                                    input bit typed, input console_result_t res);
        stim_row_t row;
        row.op    = op;
        row.data  = data;
        row.rrow  = rrow;
        row.rcol  = rcol;
        row.reps  = reps;
        row.typed = typed;
        row.res   = res;
        script.push_back(row);
    endfunction

    task automatic send_cmd(input t_opcode op, input logic [CHAR_W-1:0] data,
                            input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol,
                            input bit typed, input console_result_t res);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.data_byte   <= data;
        cmd_ch.read_row    <= rrow;
        cmd_ch.read_column <= rcol;
        drv_typed          <= typed;
        drv_typed_res      <= res;
        do @(posedge clk); while (!cmd_ch.ready);
    endtask

    // Result side: random stall bursts, none in the closing stretch.
    initial begin
        int gap;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 9);
                res_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_opcode           op;
        logic [CHAR_W-1:0] data;
        logic [ROW_W-1:0]  rrow;
        logic [COL_W-1:0]  rcol;
        int                pick;
        int                lf_span;
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.opcode      <= OP_PUT;
        cmd_ch.data_byte   <= '0;
        cmd_ch.read_row    <= '0;
        cmd_ch.read_column <= '0;
        drv_typed          <= 1'b0;
        drv_typed_res      <= '0;

        // Fresh store, edges of the read range, the acknowledge and the first puts.
        add_row(OP_READ, 8'h00, 1'b0, 5'd0, 1, 1, '{CH_SPACE, 1'b0, 1'b0, 5'd0, 1'b0, 1'b1});
        add_row(OP_READ, 8'h00, 1'b1, 5'd20, 1, 1, '{CH_SPACE, 1'b0, 1'b0, 5'd0, 1'b0, 1'b1});
        add_row(OP_READ, 8'hFF, 1'b1, 5'd31, 1, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b0, 1'b1});
        add_row(OP_ACK, 8'hFF, 1'b1, 5'd31, 1, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0});
        add_row(OP_PUT, 8'h41, 1'b0, 5'd0, 1, 1, '{8'h41, 1'b1, 1'b0, 5'd0, 1'b0, 1'b1});
        add_row(OP_PUT, CH_CR, 1'b0, 5'd0, 1, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b0, 1'b1});
        add_row(OP_PUT, 8'h00, 1'b0, 5'd0, 1, 1, '{CH_DOT, 1'b1, 1'b0, 5'd1, 1'b0, 1'b1});
        // Printable limits and the bytes just outside them.
        add_row(OP_PUT, 8'hFF, 1'b1, 5'd31, 1, 0, '0);
        add_row(OP_PUT, CH_SPACE, 1'b0, 5'd0, 1, 0, '0);
        add_row(OP_PUT, CH_TILDE, 1'b0, 5'd0, 1, 0, '0);
        add_row(OP_PUT, 8'h1F, 1'b0, 5'd0, 1, 0, '0);
        add_row(OP_PUT, 8'h7F, 1'b0, 5'd0, 1, 0, '0);
        add_row(OP_READ, 8'h00, 1'b0, 5'd1, 1, 0, '0);
        // Line feeds: next row, then arming the clear on the last row.
        add_row(OP_PUT, CH_LF, 1'b0, 5'd0, 1, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b0, 1'b1});
        add_row(OP_PUT, 8'h62, 1'b0, 5'd0, 1, 0, '0);
        add_row(OP_PUT, CH_LF, 1'b0, 5'd0, 1, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b0, 1'b1});
        add_row(OP_PUT, CH_CR, 1'b0, 5'd0, 1, 0, '0);
        add_row(OP_PUT, CH_LF, 1'b0, 5'd0, 1, 0, '0);
        add_row(OP_PUT, 8'h78, 1'b0, 5'd0, 1, 0, '0);
        add_row(OP_READ, 8'h00, 1'b1, 5'd0, 1, 0, '0);
        add_row(OP_CLEAR, 8'h00, 1'b0, 5'd0, 1, 1, '{8'h00, 1'b0, 1'b0, 5'd0, 1'b1, 1'b1});
        // Fill both rows: wrap to the next row, then wrap past the last one.
        add_row(OP_PUT, 8'h61, 1'b0, 5'd0, 22, 0, '0);
        add_row(OP_PUT, 8'h62, 1'b0, 5'd0, 20, 0, '0);
        add_row(OP_READ, 8'h00, 1'b1, 5'd20, 1, 0, '0);
        add_row(OP_PUT, 8'h63, 1'b0, 5'd0, 1, 0, '0);
        add_row(OP_READ, 8'h00, 1'b1, 5'd0, 1, 0, '0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) begin
            repeat (script[i].reps) begin
                send_cmd(script[i].op, script[i].data, script[i].rrow, script[i].rcol,
                         script[i].typed, script[i].res);
            end
        end

        lf_span = 9;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            // Pick short or long lines at random every 64 items so both the line feed paths and
            // the end-of-row wrap get exercised.
            if (n % 64 == 0) lf_span = ($urandom_range(0, 1) == 0) ? 9 : 39;
            data = CHAR_W'($urandom_range(0, 255));
            rrow = ROW_W'($urandom_range(0, 1));
            rcol = COL_W'($urandom_range(0, 31));
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                op = OP_PUT;
                case ($urandom_range(0, lf_span))
                    0:       data = CH_CR;
                    1:       data = CH_LF;
                    2:       data = CHAR_W'($urandom_range(0, 255));
                    default: data = CHAR_W'($urandom_range(32, 126));
                endcase
            end else if (pick < 88) begin
                op = OP_READ;
                if ($urandom_range(0, 7) != 0) rcol = COL_W'($urandom_range(0, COLUMNS - 1));
            end else if (pick < 96) begin
                op = OP_ACK;
            end else begin
                op = OP_CLEAR;
            end
            send_cmd(op, data, rrow, rcol, 1'b0, '0);
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
